// File: sv/dkcc_pkg.sv
// Shared types for the distinct key / class counter.
// Command and status records between the controller and the datapath.
package dkcc_pkg;

  typedef struct packed {
    logic load;        // capture input item, start probe
    logic rd_e;        // read entry memories at probe index
    logic ins;         // insert new key at probe index
    logic next_probe;  // advance probe index
    logic rd_c;        // read class slot
    logic next_cls;    // advance class slot index
    logic add_cls;     // append class to entry
    logic set_ovf;     // set sticky overflow
    logic emit;        // load result register
    logic clr_start;   // restart clearing sweep, zero counters
    logic clr_step;    // clear one entry
  } dkcc_cmd_t;

  typedef struct packed {
    logic skip;        // input item is skipped (live from input ports)
    logic ent_valid;
    logic key_match;
    logic probe_last;
    logic cls_match;
    logic cls_end;
    logic cls_full;
    logic out_free;
    logic last;
    logic clr_done;
  } dkcc_sts_t;

endpackage

// File: sv/dkcc_ctrl.sv
// Controller state machine for the distinct key / class counter.
// Depends on dkcc_pkg for the command and status records.
module dkcc_ctrl import dkcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dkcc_sts_t sts,
  output dkcc_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDE  = 3'd2;
  localparam logic [2:0] S_CMPE = 3'd3;
  localparam logic [2:0] S_RDC  = 3'd4;
  localparam logic [2:0] S_CMPC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = sts.skip ? S_DONE : S_RDE;
        end
      end
      S_RDE: begin
        cmd.rd_e = 1'b1;
        state_nxt = S_CMPE;
      end
      S_CMPE: begin
        if (!sts.ent_valid) begin
          cmd.ins = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.key_match) begin
          state_nxt = S_RDC;
        end else if (sts.probe_last) begin
          cmd.set_ovf = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.next_probe = 1'b1;
          state_nxt = S_RDE;
        end
      end
      S_RDC: begin
        cmd.rd_c = 1'b1;
        state_nxt = S_CMPC;
      end
      S_CMPC: begin
        if (sts.cls_match) begin
          state_nxt = S_DONE;
        end else if (sts.cls_end) begin
          if (sts.cls_full) cmd.set_ovf = 1'b1;
          else cmd.add_cls = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.next_cls = 1'b1;
          state_nxt = S_RDC;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            cmd.clr_start = 1'b1;
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

endmodule

// File: sv/dkcc_dp.sv
// Datapath: key, entry and class memories, counters and result register.
// Depends on dkcc_pkg for the command and status records.
module dkcc_dp import dkcc_pkg::*; #(
  parameter int TABLE_DEPTH     = 1024,
  parameter int CLASSES_PER_KEY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_key_is_real,
  input  logic [63:0] in_key,
  input  logic        in_key_missing,
  input  logic [31:0] in_target,
  input  logic        in_target_missing,
  input  logic        in_last,
  input  dkcc_cmd_t   cmd,
  output dkcc_sts_t   sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_distinct_values,
  output logic [3:0]  out_max_classes,
  output logic        out_overflow,
  output logic        out_result_last
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(CLASSES_PER_KEY + 1);
  localparam int DW  = $clog2(TABLE_DEPTH + 1);
  localparam int SAW = $clog2(TABLE_DEPTH * CLASSES_PER_KEY);
  localparam int SDEPTH = TABLE_DEPTH * CLASSES_PER_KEY;
  localparam logic [63:0] EXP_MASK = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

  logic          real_r;
  logic [63:0]   key_r;
  logic [31:0]   cls_r;
  logic          last_r;
  logic [IW-1:0] idx_r, pcnt_r, clr_r;
  logic [NW-1:0] j_r, cnt_r;
  logic [DW-1:0] distinct_r;
  logic [NW-1:0] max_r;
  logic          ovf_r;

  logic [63:0]   key_mem  [TABLE_DEPTH];
  logic [NW:0]   meta_mem [TABLE_DEPTH];   // {valid, class count}
  logic [31:0]   cls_mem  [SDEPTH];
  logic [63:0]   key_q;
  logic [NW:0]   meta_q;
  logic [31:0]   cls_q;

  logic          out_valid_r;
  logic [10:0]   out_dv_r;
  logic [3:0]    out_mc_r;
  logic          out_ovf_r;
  logic          out_last_r;

  // key normalization and skip decision on the live input
  logic [63:0]   key_n;
  logic          skip_n;
  always_comb begin
    key_n  = in_key;
    skip_n = in_key_missing | in_target_missing;
    if (real_r) begin
      if ((in_key & EXP_MASK) == EXP_MASK) skip_n = 1'b1;
      if (in_key == NEG_ZERO) key_n = '0;
    end
  end

  // start index: xor fold of the key, reduced below the depth
  logic [IW-1:0] hash;
  logic [IW-1:0] start_idx;
  always_comb begin
    hash = '0;
    for (int b = 0; b < 64; b++) hash[b % IW] = hash[b % IW] ^ key_n[b];
    start_idx = (IW'(hash) >= IW'(TABLE_DEPTH - 1) + 1'b1 && TABLE_DEPTH != (1 << IW))
                ? IW'(hash - IW'(TABLE_DEPTH)) : hash;
  end

  logic [IW-1:0] idx_inc;
  assign idx_inc = (idx_r == IW'(TABLE_DEPTH - 1)) ? '0 : idx_r + 1'b1;

  logic [SAW-1:0] slot_base, slot_raddr, slot_waddr;
  assign slot_base  = SAW'(idx_r) * SAW'(CLASSES_PER_KEY);
  assign slot_raddr = slot_base + SAW'(j_r);
  assign slot_waddr = cmd.ins ? slot_base : slot_base + SAW'(cnt_r);

  logic [NW-1:0] cnt_inc;
  assign cnt_inc = cnt_r + 1'b1;

  // entry memories
  logic          meta_we;
  logic [IW-1:0] meta_wa;
  logic [NW:0]   meta_wd;
  always_comb begin
    meta_we = cmd.clr_step | cmd.ins | cmd.add_cls;
    meta_wa = cmd.clr_step ? clr_r : idx_r;
    meta_wd = cmd.clr_step ? '0 : cmd.ins ? {1'b1, NW'(1)} : {1'b1, cnt_inc};
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (cmd.rd_e) meta_q <= meta_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) key_mem[idx_r] <= key_r;
    if (cmd.rd_e) key_q <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins || cmd.add_cls) cls_mem[slot_waddr] <= cls_r;
    if (cmd.rd_c) cls_q <= cls_mem[slot_raddr];
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key_n;
      cls_r  <= in_target;
      last_r <= in_last;
      idx_r  <= start_idx;
      pcnt_r <= '0;
      j_r    <= '0;
    end
    if (cmd.next_probe) begin
      idx_r  <= idx_inc;
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (!cmd.rd_e && !cmd.load && !cmd.next_cls) cnt_r <= meta_q[NW-1:0];
    if (cmd.next_cls) j_r <= j_r + 1'b1;
  end

  // counters, config, clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_r     <= 1'b0;
      distinct_r <= '0;
      max_r      <= '0;
      ovf_r      <= 1'b0;
      clr_r      <= '0;
    end else begin
      if (cfg_valid) real_r <= cfg_key_is_real;
      if (cmd.clr_start) begin
        distinct_r <= '0;
        max_r      <= '0;
        ovf_r      <= 1'b0;
        clr_r      <= '0;
      end else begin
        if (cmd.clr_step) clr_r <= clr_r + 1'b1;
        if (cmd.set_ovf) ovf_r <= 1'b1;
        if (cmd.ins) begin
          distinct_r <= distinct_r + 1'b1;
          if (max_r == '0) max_r <= NW'(1);
        end
        if (cmd.add_cls && cnt_inc > max_r) max_r <= cnt_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dv_r   <= 11'(distinct_r);
      out_mc_r   <= 4'(max_r);
      out_ovf_r  <= ovf_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_distinct_values = out_dv_r;
  assign out_max_classes     = out_mc_r;
  assign out_overflow        = out_ovf_r;
  assign out_result_last     = out_last_r;

  always_comb begin
    sts            = '0;
    sts.skip       = skip_n;
    sts.ent_valid  = meta_q[NW];
    sts.key_match  = (key_q == key_r);
    sts.probe_last = (pcnt_r == IW'(TABLE_DEPTH - 1));
    sts.cls_match  = (cls_q == cls_r);
    sts.cls_end    = (j_r + 1'b1 == cnt_r);
    sts.cls_full   = (cnt_r >= NW'(CLASSES_PER_KEY));
    sts.out_free   = !out_valid_r || !out_stall;
    sts.last       = last_r;
    sts.clr_done   = (clr_r == IW'(TABLE_DEPTH - 1));
  end

endmodule

// File: sv/distinct_key_class_counter_core.sv
// Distinct key / class counter: top level joining controller and datapath.
// Depends on dkcc_pkg, dkcc_ctrl and dkcc_dp.
//
// One item at a time. Each item returns one result: count of distinct keys,
// largest class-set size and sticky overflow. Keys sit in an open-addressed
// table (linear probing from a folded hash); each probe reads the single-port
// entry memories and then compares the stored key, and each class compare
// reads one slot of the class memory and then compares it. A new key is
// written into the first free entry met; a known key has its stored classes
// compared in turn, up to CLASSES_PER_KEY of them. A skipped item goes
// straight to the result. While the result register is held by out_stall,
// the next item waits. After reset and after each item marked last, a
// clearing sweep over all TABLE_DEPTH entries runs during which no item is
// accepted.
module distinct_key_class_counter_core import dkcc_pkg::*; #(
  parameter int TABLE_DEPTH     = 1024,
  parameter int CLASSES_PER_KEY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_key_is_real,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_key,
  input  logic        in_key_missing,
  input  logic signed [31:0] in_target,
  input  logic        in_target_missing,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_distinct_values,
  output logic [3:0]  out_max_classes,
  output logic        out_overflow,
  output logic        out_result_last
);

  dkcc_cmd_t cmd;
  dkcc_sts_t sts;

  assign cfg_ready = 1'b1;

  dkcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dkcc_dp #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .CLASSES_PER_KEY (CLASSES_PER_KEY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_key_is_real     (cfg_key_is_real),
    .in_key              (in_key),
    .in_key_missing      (in_key_missing),
    .in_target           (in_target),
    .in_target_missing   (in_target_missing),
    .in_last             (in_last),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distinct_values (out_distinct_values),
    .out_max_classes     (out_max_classes),
    .out_overflow        (out_overflow),
    .out_result_last     (out_result_last)
  );

endmodule

// File: verif/tb_distinct_key_class_counter_core.sv
// Testbench for distinct_key_class_counter_core: directed and random tests.
// Keeps its own table of keys and class sets to predict every result.
`timescale 1ns / 1ps

module tb_distinct_key_class_counter_core;

  localparam int DEPTH    = 1024;
  localparam int CLS_MAX  = 8;
  localparam int WD_LIMIT = 20000;
  localparam logic [63:0] EXP_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [10:0] distinct;
    logic [3:0]  max_cls;
    logic        ovf;
    logic        lst;
  } tally_t;

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_valid, cfg_key_is_real;
  logic        cfg_ready;
  logic        in_valid, in_key_missing, in_target_missing, in_last;
  logic        in_stall;
  logic [63:0] in_key;
  logic signed [31:0] in_target;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_distinct_values;
  logic [3:0]  out_max_classes;
  logic        out_overflow, out_result_last;

  distinct_key_class_counter_core DUT (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_key_is_real,
    .in_valid, .in_stall, .in_key, .in_key_missing, .in_target,
    .in_target_missing, .in_last, .out_valid, .out_stall,
    .out_distinct_values, .out_max_classes, .out_overflow, .out_result_last
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] seen_key [DEPTH];
  bit          seen_vld [DEPTH];
  int          cls_cnt  [DEPTH];
  logic [31:0] cls_val  [DEPTH][CLS_MAX];
  int          n_distinct, top_cls;
  bit          ovf_seen, real_mode;

  tally_t expected_tallies[$];
  int     errors, items_sent, results_seen, ovf_results;
  int     idle_pct, stall_pct, quiet_cycles;

  task automatic clear_tally();
    foreach (seen_vld[i]) begin
      seen_vld[i] = 0;
      cls_cnt[i] = 0;
    end
    n_distinct = 0;
    top_cls = 0;
    ovf_seen = 0;
  endtask

  task automatic tally_item(logic [63:0] key, logic kmiss, logic [31:0] tgt,
                            logic tmiss, logic lst);
    logic [63:0] k;
    bit skip, hit;
    int idx, fr;
    tally_t t;
    k = key;
    skip = kmiss || tmiss;
    idx = -1;
    fr = -1;
    if (real_mode) begin
      if ((k & EXP_BITS) == EXP_BITS) skip = 1;
      if (k == NEG_ZERO) k = '0;
    end
    if (!skip) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (seen_vld[i] && seen_key[i] == k) begin
          idx = i;
          break;
        end
        if (!seen_vld[i] && fr < 0) fr = i;
      end
      if (idx < 0) begin
        if (fr < 0) ovf_seen = 1;
        else begin
          seen_vld[fr] = 1;
          seen_key[fr] = k;
          cls_val[fr][0] = tgt;
          cls_cnt[fr] = 1;
          n_distinct++;
          if (top_cls < 1) top_cls = 1;
        end
      end else begin
        hit = 0;
        for (int j = 0; j < cls_cnt[idx]; j++) if (cls_val[idx][j] == tgt) hit = 1;
        if (!hit) begin
          if (cls_cnt[idx] >= CLS_MAX) ovf_seen = 1;
          else begin
            cls_val[idx][cls_cnt[idx]] = tgt;
            cls_cnt[idx]++;
            if (cls_cnt[idx] > top_cls) top_cls = cls_cnt[idx];
          end
        end
      end
    end
    t.distinct = n_distinct[10:0];
    t.max_cls  = top_cls[3:0];
    t.ovf      = ovf_seen;
    t.lst      = lst;
    expected_tallies = {expected_tallies, t};
    if (lst) clear_tally();
  endtask

  // one item; returns at the edge where it was accepted
  task automatic send_item(logic [63:0] key, logic kmiss, logic [31:0] tgt,
                           logic tmiss, logic lst);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_key <= key;
    in_key_missing <= kmiss;
    in_target <= tgt;
    in_target_missing <= tmiss;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    tally_item(key, kmiss, tgt, tmiss, lst);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    do @(posedge clk); while (expected_tallies.size() != 0);
  endtask

  // only while idle; the clearing sweep after a last item ignores the mode
  task automatic write_mode(bit mode);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_key_is_real <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    real_mode = mode;
  endtask

  always @(posedge clk) begin
    tally_t e;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_overflow) ovf_results++;
      if (expected_tallies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: dv=%0d mc=%0d ovf=%0b last=%0b",
          out_distinct_values, out_max_classes, out_overflow, out_result_last);
      end else begin
        e = expected_tallies.pop_front();
        if (e.distinct !== out_distinct_values || e.max_cls !== out_max_classes ||
            e.ovf !== out_overflow || e.lst !== out_result_last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch @%0t: exp dv=%0d mc=%0d ovf=%0b last=%0b, ",
                      "got dv=%0d mc=%0d ovf=%0b last=%0b"},
              $time, e.distinct, e.max_cls, e.ovf, e.lst, out_distinct_values,
              out_max_classes, out_overflow, out_result_last);
        end
      end
    end
  end

  // watchdog: cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_tallies.size());
      $display("tb_distinct_key_class_counter_core: errors");
      $finish;
    end
  end

  task automatic test_integer_keys();
    write_mode(0);
    send_item(64'h0, 0, 32'sd0, 0, 0);
    send_item('1, 0, 32'h7FFF_FFFF, 0, 0);
    send_item('1, 0, 32'h8000_0001, 0, 0);
    send_item(64'h5, 1, 32'sd3, 0, 0);          // missing key
    send_item(64'h6, 0, 32'sd3, 1, 0);          // missing target
    send_item(64'h7, 1, 32'sd3, 1, 0);
    for (int c = 0; c < 10; c++) send_item(64'h0, 0, c, 0, 0);  // class set fills, then overflows
    send_item(NEG_ZERO, 0, 32'sd1, 0, 1);       // distinct key in integer mode
  endtask

  task automatic test_real_keys();
    write_mode(1);
    send_item(64'h0, 0, 32'sd1, 0, 0);
    send_item(NEG_ZERO, 0, 32'sd2, 0, 0);       // folds onto +0
    send_item(64'h7FF0_0000_0000_0000, 0, 32'sd1, 0, 0);  // +inf
    send_item(64'hFFF0_0000_0000_0000, 0, 32'sd1, 0, 0);  // -inf
    send_item(64'h7FF8_0000_0000_0001, 0, 32'sd1, 0, 0);  // NaN
    send_item(64'h3FF0_0000_0000_0000, 0, 32'sd1, 0, 1);
  endtask

  task automatic test_random(int n, int idle, int stall, bit mode);
    logic [63:0] k;
    logic [31:0] t;
    int r;
    idle_pct = idle;
    stall_pct = stall;
    write_mode(mode);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 85) ? {$urandom_range(0, 1) ? NEG_ZERO[63:32] : 32'h0, 32'($urandom_range(0, 11))}
                   : {$urandom, $urandom};
      if (mode && $urandom_range(0, 9) == 0)
        k = {$urandom_range(0, 1) ? 12'hFFF : 12'h7FF, 20'($urandom), $urandom};
      t = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 10)) : $urandom;
      if (t == 32'h8000_0000) t = 32'h8000_0001;
      send_item(k, $urandom_range(0, 19) == 0, t, $urandom_range(0, 19) == 0,
                $urandom_range(0, 39) == 0);
      if (i == n / 2 && idle == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_key_is_real = 0;
    in_valid = 0; in_key = '0; in_key_missing = 0; in_target = '0;
    in_target_missing = 0; in_last = 0;
    items_sent = 0;
    idle_pct = 0; stall_pct = 0;
    real_mode = 0;
    clear_tally();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_integer_keys();
    test_real_keys();
    test_random(180, 0, 0, 0);
    test_random(180, 80, 0, 1);
    test_random(180, 0, 80, 0);
    test_random(180, 38, 38, 1);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("%0d items sent, %0d results checked (%0d with overflow set)",
             items_sent, results_seen, ovf_results);
    $display("integer and real key modes, missing and non-finite keys, full class sets,");
    $display("idle and stall mixes with a full drain midway");
    if (errors == 0 && expected_tallies.size() == 0) begin
      $display("tb_distinct_key_class_counter_core: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_tallies.size());
      $display("tb_distinct_key_class_counter_core: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dkcc_pkg.sv
sv/dkcc_ctrl.sv
sv/dkcc_dp.sv
sv/distinct_key_class_counter_core.sv
verif/tb_distinct_key_class_counter_core.sv
